// File: src/gbe_pkg.sv
package gbe_pkg;

   localparam logic [3:0] OP_INSERT  = 4'd0;
   localparam logic [3:0] OP_DELETE  = 4'd1;
   localparam logic [3:0] OP_LEFT    = 4'd2;
   localparam logic [3:0] OP_RIGHT   = 4'd3;
   localparam logic [3:0] OP_UNDO    = 4'd4;
   localparam logic [3:0] OP_REDO    = 4'd5;
   localparam logic [3:0] OP_GBEGIN  = 4'd6;
   localparam logic [3:0] OP_GEND    = 4'd7;
   localparam logic [3:0] OP_MARK    = 4'd8;
   localparam logic [3:0] OP_LSTART  = 4'd9;
   localparam logic [3:0] OP_LEND    = 4'd10;
   localparam logic [3:0] OP_QUERY   = 4'd11;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BOUNDARY = 2'd1;
   localparam logic [1:0] ST_FULL     = 2'd2;
   localparam logic [1:0] ST_HIST     = 2'd3;

   localparam logic [1:0] KIND_INS   = 2'd0;
   localparam logic [1:0] KIND_DEL   = 2'd1;
   localparam logic [1:0] KIND_BEGIN = 2'd2;
   localparam logic [1:0] KIND_END   = 2'd3;

   localparam logic [7:0] END_MARK = 8'h7E;
   localparam logic [7:0] NEWLINE  = 8'h0A;

   typedef struct packed {
      logic push;
      logic pop;
      logic clear;
   } stk_ctl_type;

endpackage

// File: src/gbe_stack.sv
module gbe_stack import gbe_pkg::*; #(
   parameter int DEPTH = 1024,
   parameter int EW    = 22
) (
   input  logic          clock,
   input  logic          reset,
   input  stk_ctl_type   ctl,
   input  logic [EW-1:0] wr_entry,
   output logic [EW-1:0] rd_entry,
   output logic          full,
   output logic          empty
);

   localparam int CW = $clog2(DEPTH + 1);
   localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   logic [CW-1:0] count_ff;
   logic [CW-1:0] count_in;
   logic [CW-1:0] count_dec;
   logic [EW-1:0] mem [DEPTH];
   logic [EW-1:0] rd_ff;

   assign count_dec = count_ff - 1'b1;
   assign full      = (count_ff == CW'(DEPTH));
   assign empty     = (count_ff == '0);
   assign rd_entry  = rd_ff;

   always_comb begin
      count_in = count_ff;
      if (ctl.clear) begin
         count_in = '0;
      end else if (ctl.push) begin
         count_in = count_ff + 1'b1;
      end else if (ctl.pop) begin
         count_in = count_dec;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   // top of stack is read on a pop, data is there the cycle after
   always_ff @(posedge clock) begin
      if (ctl.push) begin
         mem[count_ff[IW-1:0]] <= wr_entry;
      end
      if (ctl.pop) begin
         rd_ff <= mem[count_dec[IW-1:0]];
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CW'(DEPTH))
      else $error("stack count beyond depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      ctl.push |-> !full)
      else $error("push into a full stack");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      ctl.pop |-> !empty)
      else $error("pop from an empty stack");

endmodule

// File: src/gap_buffer_edit_engine.sv
// Gap-buffer text editor core with undo and redo. A command is taken when start is high
// and busy is low; exactly one result follows, shown for a single cycle with rsp_strobe,
// and it cannot be held off. Text lives in one single-port-read memory, history in two
// stack memories, all with registered reads, and a sequencer walks them one access at a
// time. Left over a newline scans back byte by byte to the previous newline to find the
// column. Line start and line end move the cursor one byte at a time. Undo and redo walk
// the cursor to each history entry and replay it. There is no clearing pass after reset:
// the top text entry is never written and reads as the end marker.
module gap_buffer_edit_engine import gbe_pkg::*; #(
   parameter int CAPACITY      = 4096,
   parameter int HISTORY_DEPTH = 1024
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [3:0]  req_operation,
   input  logic [7:0]  req_char_in,
   output logic        rsp_strobe,
   output logic [1:0]  rsp_status,
   output logic [11:0] rsp_cursor_pos,
   output logic [12:0] rsp_row,
   output logic [11:0] rsp_column,
   output logic [7:0]  rsp_char_at_cursor,
   output logic        rsp_mark_valid,
   output logic [11:0] rsp_mark_pos,
   output logic        rsp_modified
);

   localparam int AW = $clog2(CAPACITY);
   localparam int EW = AW + 10;
   localparam int DW = $clog2(HISTORY_DEPTH + 1) + 1;
   localparam logic [AW-1:0] TOP = AW'(CAPACITY - 1);

   typedef enum logic [4:0] {
      S_IDLE, S_INS, S_DEL, S_DEL_RD, S_LEFT, S_LEFT_RD, S_SCAN, S_SCAN_RD,
      S_RIGHT, S_RIGHT_RD, S_LSTART, S_LSTART_RD, S_LEND, S_LEND_RD,
      S_POP, S_POP_RD, S_NAV, S_CONT, S_FIN, S_CHAR
   } state_type;

   typedef enum logic [1:0] {
      M_NORMAL, M_UNDO, M_REDO
   } mode_type;

   state_type     state_ff, state_in;
   mode_type      mode_ff, mode_in;
   logic [AW-1:0] gs_ff, gs_in;
   logic [AW-1:0] ge_ff, ge_in;
   logic [12:0]   row_ff, row_in;
   logic [11:0]   col_ff, col_in;
   logic [AW-1:0] mark_pos_ff, mark_pos_in;
   logic          mark_ff, mark_in;
   logic          mod_ff, mod_in;
   logic [7:0]    byte_ff, byte_in;
   logic [AW-1:0] ent_pos_ff, ent_pos_in;
   logic [1:0]    ent_kind_ff, ent_kind_in;
   logic [7:0]    ent_byte_ff, ent_byte_in;
   logic [DW-1:0] depth_ff, depth_in;
   logic [AW-1:0] scan_i_ff, scan_i_in;
   logic [11:0]   scan_n_ff, scan_n_in;
   logic [1:0]    status_ff, status_in;
   logic          strobe_ff, strobe_in;
   logic [7:0]    char_ff, char_in;

   logic [7:0]    txt_mem [CAPACITY];
   logic [7:0]    txt_rdata_ff;
   logic [AW-1:0] txt_raddr;
   logic [AW-1:0] txt_waddr;
   logic [7:0]    txt_wdata;
   logic          txt_we;

   stk_ctl_type   undo_ctl, redo_ctl;
   logic [EW-1:0] push_data;
   logic [EW-1:0] undo_rdata, redo_rdata, src_rdata;
   logic          undo_full, undo_empty, redo_full, redo_empty;
   logic          dst_full, src_empty;
   logic          push_go, pop_go, clear_redo;
   state_type     ret_state;

   gbe_stack #(.DEPTH(HISTORY_DEPTH), .EW(EW)) u_undo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (undo_ctl),
      .wr_entry (push_data),
      .rd_entry (undo_rdata),
      .full     (undo_full),
      .empty    (undo_empty)
   );

   gbe_stack #(.DEPTH(HISTORY_DEPTH), .EW(EW)) u_redo (
      .clock    (clock),
      .reset    (reset),
      .ctl      (redo_ctl),
      .wr_entry (push_data),
      .rd_entry (redo_rdata),
      .full     (redo_full),
      .empty    (redo_empty)
   );

   // undo pops the undo stack and records on redo; normal edits and redo record on undo
   assign dst_full  = (mode_ff == M_UNDO) ? redo_full : undo_full;
   assign src_empty = (mode_ff == M_UNDO) ? undo_empty : redo_empty;
   assign src_rdata = (mode_ff == M_UNDO) ? undo_rdata : redo_rdata;
   assign ret_state = (mode_ff == M_NORMAL) ? S_FIN : S_NAV;

   always_comb begin
      state_in    = state_ff;
      mode_in     = mode_ff;
      gs_in       = gs_ff;
      ge_in       = ge_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      mark_pos_in = mark_pos_ff;
      mark_in     = mark_ff;
      mod_in      = mod_ff;
      byte_in     = byte_ff;
      ent_pos_in  = ent_pos_ff;
      ent_kind_in = ent_kind_ff;
      ent_byte_in = ent_byte_ff;
      depth_in    = depth_ff;
      scan_i_in   = scan_i_ff;
      scan_n_in   = scan_n_ff;
      status_in   = status_ff;
      strobe_in   = 1'b0;
      char_in     = char_ff;
      txt_raddr   = ge_ff;
      txt_waddr   = gs_ff;
      txt_wdata   = byte_ff;
      txt_we      = 1'b0;
      push_data   = {gs_ff, KIND_INS, byte_ff};
      push_go     = 1'b0;
      pop_go      = 1'b0;
      clear_redo  = 1'b0;
      undo_ctl    = '0;
      redo_ctl    = '0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               byte_in   = req_char_in;
               mode_in   = M_NORMAL;
               status_in = ST_OK;
               depth_in  = '0;
               state_in  = S_FIN;
               unique case (req_operation)
                  OP_INSERT: state_in = S_INS;
                  OP_DELETE: state_in = S_DEL;
                  OP_LEFT:   state_in = S_LEFT;
                  OP_RIGHT:  state_in = S_RIGHT;
                  OP_UNDO: begin
                     mode_in = M_UNDO;
                     if (undo_empty) begin
                        status_in = ST_BOUNDARY;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  OP_REDO: begin
                     mode_in = M_REDO;
                     if (redo_empty) begin
                        status_in = ST_BOUNDARY;
                     end else begin
                        state_in = S_POP;
                     end
                  end
                  OP_GBEGIN, OP_GEND: begin
                     if (undo_full) begin
                        status_in = ST_HIST;
                     end else begin
                        push_go   = 1'b1;
                        push_data = {{AW{1'b0}},
                           (req_operation == OP_GBEGIN) ? KIND_BEGIN : KIND_END, 8'd0};
                     end
                  end
                  OP_MARK: begin
                     mark_pos_in = gs_ff;
                     mark_in     = 1'b1;
                  end
                  OP_LSTART: state_in = S_LSTART;
                  OP_LEND:   state_in = S_LEND;
                  OP_QUERY:  state_in = S_FIN;
                  default:   status_in = ST_BOUNDARY;
               endcase
            end
         end

         S_INS: begin
            state_in = S_FIN;
            if (gs_ff >= ge_ff) begin
               status_in = ST_FULL;
            end else if (dst_full) begin
               status_in = ST_HIST;
            end else begin
               push_go     = 1'b1;
               push_data   = {gs_ff, KIND_INS, byte_ff};
               clear_redo  = (mode_ff == M_NORMAL);
               txt_we      = 1'b1;
               txt_waddr   = gs_ff;
               txt_wdata   = byte_ff;
               gs_in       = gs_ff + 1'b1;
               if (byte_ff == NEWLINE) begin
                  row_in = row_ff + 13'd1;
                  col_in = '0;
               end else begin
                  col_in = col_ff + 12'd1;
               end
               mark_in     = 1'b0;
               mark_pos_in = '0;
               mod_in      = 1'b1;
               if (mode_ff != M_NORMAL) begin
                  state_in = S_CONT;
               end
            end
         end

         S_DEL: begin
            if (ge_ff >= TOP) begin
               status_in = ST_BOUNDARY;
               state_in  = S_FIN;
            end else if (dst_full) begin
               status_in = ST_HIST;
               state_in  = S_FIN;
            end else begin
               txt_raddr = ge_ff;
               state_in  = S_DEL_RD;
            end
         end

         S_DEL_RD: begin
            push_go     = 1'b1;
            push_data   = {gs_ff, KIND_DEL, txt_rdata_ff};
            clear_redo  = (mode_ff == M_NORMAL);
            ge_in       = ge_ff + 1'b1;
            mark_in     = 1'b0;
            mark_pos_in = '0;
            mod_in      = 1'b1;
            state_in    = (mode_ff == M_NORMAL) ? S_FIN : S_CONT;
         end

         S_LEFT: begin
            if (gs_ff == '0 || ge_ff == '0) begin
               status_in = ST_BOUNDARY;
               state_in  = S_FIN;
            end else begin
               txt_raddr = gs_ff - 1'b1;
               state_in  = S_LEFT_RD;
            end
         end

         S_LEFT_RD: begin
            txt_we    = 1'b1;
            txt_waddr = ge_ff - 1'b1;
            txt_wdata = txt_rdata_ff;
            gs_in     = gs_ff - 1'b1;
            ge_in     = ge_ff - 1'b1;
            if (txt_rdata_ff == NEWLINE) begin
               // column is the run of bytes back to the previous newline
               row_in    = row_ff - 13'd1;
               scan_i_in = gs_ff - 1'b1;
               scan_n_in = '0;
               state_in  = S_SCAN;
            end else begin
               col_in   = col_ff - 12'd1;
               state_in = ret_state;
            end
         end

         S_SCAN: begin
            if (scan_i_ff == '0) begin
               col_in   = scan_n_ff;
               state_in = ret_state;
            end else begin
               txt_raddr = scan_i_ff - 1'b1;
               state_in  = S_SCAN_RD;
            end
         end

         S_SCAN_RD: begin
            if (txt_rdata_ff == NEWLINE) begin
               col_in   = scan_n_ff;
               state_in = ret_state;
            end else begin
               scan_n_in = scan_n_ff + 12'd1;
               scan_i_in = scan_i_ff - 1'b1;
               state_in  = S_SCAN;
            end
         end

         S_RIGHT: begin
            if (ge_ff >= TOP) begin
               status_in = ST_BOUNDARY;
               state_in  = S_FIN;
            end else begin
               txt_raddr = ge_ff;
               state_in  = S_RIGHT_RD;
            end
         end

         S_RIGHT_RD: begin
            txt_we    = 1'b1;
            txt_waddr = gs_ff;
            txt_wdata = txt_rdata_ff;
            gs_in     = gs_ff + 1'b1;
            ge_in     = ge_ff + 1'b1;
            if (txt_rdata_ff == NEWLINE) begin
               row_in = row_ff + 13'd1;
               col_in = '0;
            end else begin
               col_in = col_ff + 12'd1;
            end
            state_in = ret_state;
         end

         S_LSTART: begin
            if (gs_ff == '0) begin
               state_in = S_FIN;
            end else begin
               txt_raddr = gs_ff - 1'b1;
               state_in  = S_LSTART_RD;
            end
         end

         S_LSTART_RD: begin
            if (txt_rdata_ff == NEWLINE) begin
               state_in = S_FIN;
            end else begin
               txt_we    = 1'b1;
               txt_waddr = ge_ff - 1'b1;
               txt_wdata = txt_rdata_ff;
               gs_in     = gs_ff - 1'b1;
               ge_in     = ge_ff - 1'b1;
               col_in    = col_ff - 12'd1;
               state_in  = S_LSTART;
            end
         end

         S_LEND: begin
            if (ge_ff >= TOP) begin
               state_in = S_FIN;
            end else begin
               txt_raddr = ge_ff;
               state_in  = S_LEND_RD;
            end
         end

         S_LEND_RD: begin
            if (txt_rdata_ff == NEWLINE) begin
               state_in = S_FIN;
            end else begin
               txt_we    = 1'b1;
               txt_waddr = gs_ff;
               txt_wdata = txt_rdata_ff;
               gs_in     = gs_ff + 1'b1;
               ge_in     = ge_ff + 1'b1;
               col_in    = col_ff + 12'd1;
               state_in  = S_LEND;
            end
         end

         S_POP: begin
            if (src_empty) begin
               state_in = S_FIN;
            end else begin
               pop_go   = 1'b1;
               state_in = S_POP_RD;
            end
         end

         S_POP_RD: begin
            ent_pos_in  = src_rdata[EW-1:10];
            ent_kind_in = src_rdata[9:8];
            ent_byte_in = src_rdata[7:0];
            case (src_rdata[9:8])
               KIND_INS, KIND_DEL: state_in = S_NAV;
               default: begin
                  // a replayed group marker is recorded as its opposite
                  if (src_rdata[9:8] == KIND_BEGIN) begin
                     depth_in  = depth_ff - 1'b1;
                     push_data = {{AW{1'b0}}, KIND_END, 8'd0};
                  end else begin
                     depth_in  = depth_ff + 1'b1;
                     push_data = {{AW{1'b0}}, KIND_BEGIN, 8'd0};
                  end
                  if (dst_full) begin
                     status_in = ST_HIST;
                     state_in  = S_FIN;
                  end else begin
                     push_go  = 1'b1;
                     state_in = S_CONT;
                  end
               end
            endcase
         end

         S_NAV: begin
            if (gs_ff < ent_pos_ff) begin
               state_in = S_RIGHT;
            end else if (gs_ff > ent_pos_ff) begin
               state_in = S_LEFT;
            end else if (ent_kind_ff == KIND_INS) begin
               state_in = S_DEL;
            end else begin
               byte_in  = ent_byte_ff;
               state_in = S_INS;
            end
         end

         S_CONT: begin
            state_in = (depth_ff != '0) ? S_POP : S_FIN;
         end

         S_FIN: begin
            txt_raddr = ge_ff;
            state_in  = S_CHAR;
         end

         S_CHAR: begin
            char_in   = (ge_ff == TOP) ? END_MARK : txt_rdata_ff;
            strobe_in = 1'b1;
            state_in  = S_IDLE;
         end

         default: state_in = S_IDLE;
      endcase

      if (push_go) begin
         if (mode_in == M_UNDO) begin
            redo_ctl.push = 1'b1;
         end else begin
            undo_ctl.push = 1'b1;
         end
      end
      if (pop_go) begin
         if (mode_ff == M_UNDO) begin
            undo_ctl.pop = 1'b1;
         end else begin
            redo_ctl.pop = 1'b1;
         end
      end
      if (clear_redo) begin
         redo_ctl.clear = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         mode_ff     <= M_NORMAL;
         gs_ff       <= '0;
         ge_ff       <= TOP;
         row_ff      <= 13'd1;
         col_ff      <= '0;
         mark_pos_ff <= '0;
         mark_ff     <= 1'b0;
         mod_ff      <= 1'b0;
         depth_ff    <= '0;
         status_ff   <= ST_OK;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         mode_ff     <= mode_in;
         gs_ff       <= gs_in;
         ge_ff       <= ge_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         mark_pos_ff <= mark_pos_in;
         mark_ff     <= mark_in;
         mod_ff      <= mod_in;
         depth_ff    <= depth_in;
         status_ff   <= status_in;
         strobe_ff   <= strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_ff     <= byte_in;
      ent_pos_ff  <= ent_pos_in;
      ent_kind_ff <= ent_kind_in;
      ent_byte_ff <= ent_byte_in;
      scan_i_ff   <= scan_i_in;
      scan_n_ff   <= scan_n_in;
      char_ff     <= char_in;
   end

   // text store; the top entry is never written and reads as the end marker
   always_ff @(posedge clock) begin
      if (txt_we) begin
         txt_mem[txt_waddr] <= txt_wdata;
      end
      txt_rdata_ff <= txt_mem[txt_raddr];
   end

   assign busy               = (state_ff != S_IDLE);
   assign rsp_strobe         = strobe_ff;
   assign rsp_status         = status_ff;
   assign rsp_cursor_pos     = 12'(gs_ff);
   assign rsp_row            = row_ff;
   assign rsp_column         = col_ff;
   assign rsp_char_at_cursor = char_ff;
   assign rsp_mark_valid     = mark_ff;
   assign rsp_mark_pos       = 12'(mark_pos_ff);
   assign rsp_modified       = mod_ff;

   a_gap_order: assert property (@(posedge clock) disable iff (reset)
      (gs_ff <= ge_ff) && (ge_ff <= TOP))
      else $error("gap pointers out of order");

   a_top_untouched: assert property (@(posedge clock) disable iff (reset)
      txt_we |-> (txt_waddr != TOP))
      else $error("write to the end marker entry");

   a_strobe_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result shown while still working");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("command taken without going busy");

   a_one_stack_op: assert property (@(posedge clock) disable iff (reset)
      !(undo_ctl.push && redo_ctl.push))
      else $error("both stacks pushed at once");

endmodule
